>>> sv/mfpr_pkg.sv
package mfpr_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 6;
	localparam int HDR_LEN = 3;

	// configuration register indexes
	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	// one closed frame, handed from the front to the back
	typedef struct packed {
		logic              bank;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] h0;
		logic [BYTE_W-1:0] h1;
		logic [BYTE_W-1:0] h2;
	} frame_desc_t;

	// queue handshake between front, queue and back
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

>>> sv/mfpr_store.sv
module mfpr_store #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH):0]         waddr,
	input  logic [mfpr_pkg::BYTE_W-1:0]    wdata,
	input  logic [$clog2(DEPTH):0]         raddr,
	output logic [mfpr_pkg::BYTE_W-1:0]    rdata
);

	localparam int AW      = $clog2(DEPTH) + 1;
	localparam int ENTRIES = 2 ** AW;

	// two banks of frame bytes, bank select is the address MSB
	logic [mfpr_pkg::BYTE_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> sv/mfpr_queue.sv
module mfpr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mfpr_pkg::queue_ctl_t    ctl,
	input  mfpr_pkg::frame_desc_t   push_desc,
	output mfpr_pkg::queue_stat_t   stat,
	output mfpr_pkg::frame_desc_t   head
);

	// two-entry descriptor queue, one entry per store bank
	mfpr_pkg::frame_desc_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign stat.full  = count_q[1];
	assign stat.empty = (count_q == 2'd0);
	assign head       = entry_q[rd_ptr_q];

endmodule

>>> sv/mfpr_front.sv
module mfpr_front #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mfpr_pkg::BYTE_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mfpr_pkg::BYTE_W-1:0]   s_tdata,
	input  mfpr_pkg::queue_stat_t         q_stat,
	output logic                          q_push,
	output mfpr_pkg::frame_desc_t         q_desc,
	output logic                          ram_we,
	output logic [$clog2(DEPTH):0]        ram_waddr,
	output logic [mfpr_pkg::BYTE_W-1:0]   ram_wdata
);

	localparam int          CW    = $clog2(DEPTH);
	localparam logic [CW-1:0] LIMIT = CW'(DEPTH - 1);

	logic [mfpr_pkg::BYTE_W-1:0] start_marker_q;
	logic [mfpr_pkg::BYTE_W-1:0] end_marker_q;
	logic                        in_frame_q;
	logic [CW-1:0]               count_q;
	logic                        bank_q;
	logic [mfpr_pkg::BYTE_W-1:0] h0_q, h1_q, h2_q;

	logic beat;
	logic is_open;
	logic is_close;
	logic is_store;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= 8'd2;
			end_marker_q   <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfpr_pkg::CFG_START_MARKER: start_marker_q <= cfg_data;
				mfpr_pkg::CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default:                    start_marker_q <= start_marker_q;
			endcase
		end
	end

	// classify the beat; hold off only while both banks are pending
	assign s_tready = ~q_stat.full;
	assign beat     = s_tvalid & s_tready;
	assign is_open  = beat & ~in_frame_q & (s_tdata == start_marker_q);
	assign is_close = beat & in_frame_q & (s_tdata == end_marker_q);
	assign is_store = beat & in_frame_q & (s_tdata != end_marker_q) & (count_q < LIMIT);

	// frame tracking and header capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			bank_q     <= 1'b0;
			h0_q       <= '0;
			h1_q       <= '0;
			h2_q       <= '0;
		end else begin
			if (is_open) begin
				in_frame_q <= 1'b1;
				count_q    <= '0;
				h0_q       <= '0;
				h1_q       <= '0;
				h2_q       <= '0;
			end else if (is_close) begin
				in_frame_q <= 1'b0;
				count_q    <= '0;
				bank_q     <= ~bank_q;
			end else if (is_store) begin
				count_q <= count_q + CW'(1);
				if (count_q == CW'(0)) h0_q <= s_tdata;
				if (count_q == CW'(1)) h1_q <= s_tdata;
				if (count_q == CW'(2)) h2_q <= s_tdata;
			end
		end
	end

	assign ram_we    = is_store;
	assign ram_waddr = {bank_q, count_q};
	assign ram_wdata = s_tdata;

	assign q_push      = is_close;
	assign q_desc.bank = bank_q;
	assign q_desc.len  = mfpr_pkg::LEN_W'(count_q);
	assign q_desc.h0   = h0_q;
	assign q_desc.h1   = h1_q;
	assign q_desc.h2   = h2_q;

endmodule

>>> sv/mfpr_back.sv
module mfpr_back #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfpr_pkg::queue_stat_t         q_stat,
	input  mfpr_pkg::frame_desc_t         q_head,
	output logic                          q_pop,
	output logic [$clog2(DEPTH):0]        ram_raddr,
	input  logic [mfpr_pkg::BYTE_W-1:0]   ram_rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int CW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RD   = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

	back_state_t           state_q;
	mfpr_pkg::frame_desc_t desc_q;
	logic [CW-1:0]         idx_q;
	logic                  hdr_only;
	logic                  last_beat;
	logic                  out_done;
	logic [mfpr_pkg::BYTE_W-1:0] payload;

	assign hdr_only  = (desc_q.len <= mfpr_pkg::LEN_W'(mfpr_pkg::HDR_LEN));
	assign last_beat = hdr_only | ((mfpr_pkg::LEN_W'(idx_q) + 6'd1) == desc_q.len);
	assign out_done  = (state_q == B_OUT) & m_tready;

	// walk one frame: load descriptor, read each payload byte, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						idx_q <= CW'(mfpr_pkg::HDR_LEN);
						if (q_head.len <= mfpr_pkg::LEN_W'(mfpr_pkg::HDR_LEN)) begin
							state_q <= B_OUT;
						end else begin
							state_q <= B_RD;
						end
					end
				end
				B_RD: begin
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (m_tready) begin
						if (last_beat) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= B_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == B_IDLE) && !q_stat.empty) begin
			desc_q <= q_head;
		end
	end

	assign q_pop     = out_done & last_beat;
	assign ram_raddr = {desc_q.bank, idx_q};
	assign payload   = hdr_only ? '0 : ram_rdata;

	assign m_tvalid = (state_q == B_OUT);
	assign m_tdata  = {2'b00, payload, desc_q.len, desc_q.h2, desc_q.h1, desc_q.h0};
	assign m_tuser  = ~hdr_only;
	assign m_tlast  = last_beat;

endmodule

>>> sv/marker_framed_packet_receiver_core.sv
// channel  | dir | beat content
// s_*      | in  | tdata[7:0] rx_byte
// m_*      | out | tdata: unit_address, op_mode, declared_size, frame_length,
//          |     |   payload_byte; tuser payload_valid; tlast last
// cfg_*    | in  | index 0 start_marker, index 1 end_marker, one write per cycle
//
// Input takes one byte per cycle. Two store banks ping-pong, so one frame can
// drain while the next fills; s_tready drops only while two closed frames wait.
// Output: each frame first loads its descriptor in B_IDLE; a header-only beat
// follows straight in B_OUT, each payload beat passes B_RD (store read), then
// B_OUT (held), plus waiting on m_tready.
// arst_n clears markers to 2/3, frame state and the queue; no clearing pass.
module marker_framed_packet_receiver_core #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] unit_address, [15:8] op_mode,
	                               // [23:16] declared_size, [29:24] frame_length,
	                               // [37:30] payload_byte, [39:38] zero
	output logic        m_tuser,   // [0] payload_valid
	output logic        m_tlast
);

	localparam int AW = $clog2(DEPTH) + 1;

	mfpr_pkg::queue_ctl_t  q_ctl;
	mfpr_pkg::queue_stat_t q_stat;
	mfpr_pkg::frame_desc_t q_desc;
	mfpr_pkg::frame_desc_t q_head;
	logic                  q_push;
	logic                  q_pop;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign q_ctl = '{push: q_push, pop: q_pop};

	mfpr_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_desc    (q_desc),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	mfpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_desc (q_desc),
		.stat      (q_stat),
		.head      (q_head)
	);

	mfpr_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mfpr_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
